[rtl/ray_box_nearest_pick_macros.svh]
// Assertion helpers for the block's modules; rbnp_back is the one that uses them.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef RAY_BOX_NEAREST_PICK_MACROS_SVH
`define RAY_BOX_NEAREST_PICK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBNP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBNP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rbnp_pkg.sv]
`default_nettype none

package rbnp_pkg;

    localparam int COORD_W       = 32;
    localparam int LEN_W         = 31;
    localparam int IDX_W         = 4;
    localparam int FRAC_W        = 16;
    localparam int NUM_W         = COORD_W + 2;
    localparam int QUO_W         = 32;
    localparam int TABLE_SLOTS   = 2 ** IDX_W;
    localparam int MAX_BOXES_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PICK  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [LEN_W-1:0]   len_t;
    typedef logic        [IDX_W-1:0]   idx_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic signed [QUO_W-1:0]   quo_t;

    // For a write item the b vector carries the half extent, not the size.
    typedef struct packed {
        logic   kind;
        idx_t   idx;
        coord_t ax;
        coord_t ay;
        coord_t az;
        coord_t bx;
        coord_t by;
        coord_t bz;
        len_t   len;
        logic   active;
    } item_t;

    typedef struct packed {
        logic   start;
        num_t   num;
        coord_t den;
    } div_req_t;

    typedef struct packed {
        logic done;
        quo_t q;
    } div_rsp_t;

endpackage

`default_nettype wire

[rtl/rbnp_if.sv]
`default_nettype none

interface rbnp_in_if;
    import rbnp_pkg::*;

    logic   valid;
    logic   ready;
    logic   kind;
    idx_t   entry_index;
    coord_t vec_a_x;
    coord_t vec_a_y;
    coord_t vec_a_z;
    coord_t vec_b_x;
    coord_t vec_b_y;
    coord_t vec_b_z;
    len_t   ray_length;
    logic   entry_active;

    modport source (
        output valid, kind, entry_index, vec_a_x, vec_a_y, vec_a_z,
               vec_b_x, vec_b_y, vec_b_z, ray_length, entry_active,
        input  ready
    );

    modport sink (
        input  valid, kind, entry_index, vec_a_x, vec_a_y, vec_a_z,
               vec_b_x, vec_b_y, vec_b_z, ray_length, entry_active,
        output ready
    );
endinterface

interface rbnp_out_if;
    import rbnp_pkg::*;

    logic valid;
    logic ready;
    logic hit;
    idx_t box_index;
    len_t hit_distance;

    modport source (
        output valid, hit, box_index, hit_distance,
        input  ready
    );

    modport sink (
        input  valid, hit, box_index, hit_distance,
        output ready
    );
endinterface

`default_nettype wire

[rtl/rbnp_front.sv]
`default_nettype none

module rbnp_front #(
    parameter int MAX_BOXES = rbnp_pkg::MAX_BOXES_DEF
) (
    rbnp_in_if.sink          in_ch,
    input  wire logic        full,
    output logic             push,
    output rbnp_pkg::item_t  push_item
);
    import rbnp_pkg::*;

    // floor(3 * size / 4); the result always fits back into 32 bits.
    function automatic coord_t half_of(input coord_t s);
        logic signed [COORD_W+1:0] t;
        begin
            t = {{2{s[COORD_W-1]}}, s} + {s[COORD_W-1], s, 1'b0};
            return t[COORD_W+1:2];
        end
    endfunction

    logic write_kept;

    assign in_ch.ready = !full;

    // Writes to slots beyond the table are dropped here and never queued.
    assign write_kept = (in_ch.kind == KIND_WRITE) && (int'(in_ch.entry_index) < MAX_BOXES);
    assign push = in_ch.valid && !full && ((in_ch.kind == KIND_PICK) || write_kept);

    always_comb
    begin
        push_item.kind   = in_ch.kind;
        push_item.idx    = in_ch.entry_index;
        push_item.ax     = in_ch.vec_a_x;
        push_item.ay     = in_ch.vec_a_y;
        push_item.az     = in_ch.vec_a_z;
        push_item.len    = in_ch.ray_length;
        push_item.active = in_ch.entry_active;
        if (in_ch.kind == KIND_WRITE)
        begin
            push_item.bx = half_of(in_ch.vec_b_x);
            push_item.by = half_of(in_ch.vec_b_y);
            push_item.bz = half_of(in_ch.vec_b_z);
        end
        else
        begin
            push_item.bx = in_ch.vec_b_x;
            push_item.by = in_ch.vec_b_y;
            push_item.bz = in_ch.vec_b_z;
        end
    end

endmodule

`default_nettype wire

[rtl/rbnp_fifo.sv]
`default_nettype none

module rbnp_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rbnp_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output rbnp_pkg::item_t      head
);
    import rbnp_pkg::*;

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/rbnp_div.sv]
`default_nettype none

module rbnp_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rbnp_pkg::div_req_t req,
    output rbnp_pkg::div_rsp_t      rsp
);
    import rbnp_pkg::*;

    localparam int DIVD_W = NUM_W + FRAC_W;

    // Truncated signed quotient, clamped to the 32-bit signed range.
    function automatic quo_t saturate(input logic [QUO_W-1:0] mag, input logic neg);
        logic [QUO_W-1:0] lim;
        begin
            lim = {1'b1, {(QUO_W-1){1'b0}}};
            if (!neg)
            begin
                return mag[QUO_W-1] ? quo_t'({1'b0, {(QUO_W-1){1'b1}}}) : quo_t'(mag);
            end
            else
            begin
                return (mag > lim) ? quo_t'(lim) : quo_t'(-mag);
            end
        end
    endfunction

    logic [NUM_W-1:0]   num_abs;
    logic [COORD_W-1:0] den_abs;
    logic [DIVD_W-1:0]  dividend;
    logic               ovf;
    logic               start_neg;
    logic [QUO_W:0]     r2;
    logic               ge;
    logic [QUO_W:0]     rdiff;
    logic [QUO_W-1:0]   q_step;

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         cnt_reg;
    logic [QUO_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   low_reg;
    logic [QUO_W-1:0]   qacc_reg;
    logic [COORD_W-1:0] dmag_reg;
    logic               neg_reg;
    quo_t               q_reg;

    assign num_abs   = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    assign den_abs   = req.den[COORD_W-1] ? COORD_W'(-req.den) : COORD_W'(req.den);
    assign dividend  = {num_abs, {FRAC_W{1'b0}}};
    assign start_neg = req.num[NUM_W-1] ^ req.den[COORD_W-1];
    // A quotient of 2^32 or more saturates whatever its sign.
    assign ovf       = 64'(dividend) >= {den_abs, {QUO_W{1'b0}}};

    // One restoring step a cycle; the remainder stays below the divisor.
    assign r2     = {rem_reg, low_reg[QUO_W-1]};
    assign ge     = r2 >= {1'b0, dmag_reg};
    assign rdiff  = r2 - {1'b0, dmag_reg};
    assign q_step = {qacc_reg[QUO_W-2:0], ge};

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= QUO_W'(dividend[DIVD_W-1:QUO_W]);
            low_reg  <= dividend[QUO_W-1:0];
            qacc_reg <= '0;
            dmag_reg <= den_abs;
            neg_reg  <= start_neg;
            if (ovf)
            begin
                q_reg <= saturate({QUO_W{1'b1}}, start_neg);
            end
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? rdiff[QUO_W-1:0] : r2[QUO_W-1:0];
            low_reg  <= {low_reg[QUO_W-2:0], 1'b0};
            qacc_reg <= q_step;
            if (cnt_reg == '0)
            begin
                q_reg <= saturate(q_step, neg_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= 5'(QUO_W - 1);
                if (ovf)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/rbnp_back.sv]
`default_nettype none
`include "ray_box_nearest_pick_macros.svh"

module rbnp_back #(
    parameter int MAX_BOXES = rbnp_pkg::MAX_BOXES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire rbnp_pkg::item_t    q_item,
    output logic                    q_pop,
    output rbnp_pkg::div_req_t      div_req,
    input  wire rbnp_pkg::div_rsp_t div_rsp,
    rbnp_out_if.source              out_ch
);
    import rbnp_pkg::*;

    localparam int SCAN = (MAX_BOXES < TABLE_SLOTS) ? MAX_BOXES : TABLE_SLOTS;
    localparam int IW   = (SCAN > 1) ? $clog2(SCAN) : 1;
    localparam int CW   = $clog2(SCAN + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BOX    = 3'd1;
    localparam logic [2:0] ST_AXIS   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_DSTART = 3'd4;
    localparam logic [2:0] ST_DWAIT  = 3'd5;
    localparam logic [2:0] ST_MERGE  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    coord_t ctr_x_reg [SCAN];
    coord_t ctr_y_reg [SCAN];
    coord_t ctr_z_reg [SCAN];
    coord_t half_x_reg [SCAN];
    coord_t half_y_reg [SCAN];
    coord_t half_z_reg [SCAN];
    logic [SCAN-1:0] valid_reg;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    coord_t        org_x_reg, org_y_reg, org_z_reg;
    coord_t        dir_x_reg, dir_y_reg, dir_z_reg;
    len_t          len_reg;
    logic [CW-1:0] box_cnt_reg;
    logic [1:0]    axis_reg;
    logic          side_reg;
    quo_t          near_reg;
    quo_t          far_reg;
    quo_t          t0_reg;
    logic signed [COORD_W:0] lo_reg;
    logic signed [COORD_W:0] hi_reg;
    logic          found_reg;
    idx_t          best_idx_reg;
    quo_t          best_dist_reg;
    logic          out_valid_reg;
    logic          out_hit_reg;
    idx_t          out_idx_reg;
    len_t          out_dist_reg;

    logic [IW-1:0] cur;
    coord_t        ctr_sel, half_sel, org_sel, dir_sel;
    logic signed [COORD_W:0] org_ext;
    logic          in_slab;
    quo_t          tmin, tmax, nn, ff;
    logic          axis_pass;
    quo_t          new_near, new_far;
    logic          better;
    logic          out_free;
    quo_t          len_ext;

    assign cur     = box_cnt_reg[IW-1:0];
    assign len_ext = quo_t'({1'b0, len_reg});

    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                ctr_sel = ctr_x_reg[cur]; half_sel = half_x_reg[cur];
                org_sel = org_x_reg;      dir_sel  = dir_x_reg;
            end
            AXIS_Y:
            begin
                ctr_sel = ctr_y_reg[cur]; half_sel = half_y_reg[cur];
                org_sel = org_y_reg;      dir_sel  = dir_y_reg;
            end
            default:
            begin
                ctr_sel = ctr_z_reg[cur]; half_sel = half_z_reg[cur];
                org_sel = org_z_reg;      dir_sel  = dir_z_reg;
            end
        endcase
    end

    assign org_ext = {org_sel[COORD_W-1], org_sel};
    assign in_slab = (org_ext >= lo_reg) && (org_ext <= hi_reg);

    assign tmin = (t0_reg < div_rsp.q) ? t0_reg : div_rsp.q;
    assign tmax = (t0_reg < div_rsp.q) ? div_rsp.q : t0_reg;
    // Merge uses t1 held in the divider's result register.
    assign nn   = (tmin > near_reg) ? tmin : near_reg;
    assign ff   = (tmax < far_reg) ? tmax : far_reg;

    always_comb
    begin
        if (state_reg == ST_MERGE)
        begin
            axis_pass = (nn <= ff);
            new_near  = nn;
            new_far   = ff;
        end
        else
        begin
            axis_pass = in_slab;
            new_near  = near_reg;
            new_far   = far_reg;
        end
    end

    assign better   = !found_reg || (new_near < best_dist_reg);
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.kind == KIND_PICK)
                    begin
                        state_next = ST_BOX;
                    end
                end
            end
            ST_BOX:
            begin
                if (box_cnt_reg == CW'(SCAN))
                begin
                    state_next = ST_DONE;
                end
                else if (valid_reg[cur])
                begin
                    state_next = ST_AXIS;
                end
            end
            ST_AXIS:   state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (dir_sel != '0)
                begin
                    state_next = ST_DSTART;
                end
                else if (!axis_pass || axis_reg == AXIS_Z)
                begin
                    state_next = ST_BOX;
                end
                else
                begin
                    state_next = ST_AXIS;
                end
            end
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = side_reg ? ST_MERGE : ST_DSTART;
                end
            end
            ST_MERGE:
            begin
                state_next = (!axis_pass || axis_reg == AXIS_Z) ? ST_BOX : ST_AXIS;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        div_req.start = (state_reg == ST_DSTART);
        div_req.num   = side_reg ? (NUM_W'(hi_reg) - NUM_W'(org_ext))
                                 : (NUM_W'(lo_reg) - NUM_W'(org_ext));
        div_req.den   = dir_sel;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.hit          = out_hit_reg;
    assign out_ch.box_index    = out_idx_reg;
    assign out_ch.hit_distance = out_dist_reg;

    // Table payload carries no reset; only the active flags do.
    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.kind == KIND_WRITE)
        begin
            ctr_x_reg[q_item.idx[IW-1:0]]  <= q_item.ax;
            ctr_y_reg[q_item.idx[IW-1:0]]  <= q_item.ay;
            ctr_z_reg[q_item.idx[IW-1:0]]  <= q_item.az;
            half_x_reg[q_item.idx[IW-1:0]] <= q_item.bx;
            half_y_reg[q_item.idx[IW-1:0]] <= q_item.by;
            half_z_reg[q_item.idx[IW-1:0]] <= q_item.bz;
        end
        if (q_pop && q_item.kind == KIND_PICK)
        begin
            org_x_reg <= q_item.ax;
            org_y_reg <= q_item.ay;
            org_z_reg <= q_item.az;
            dir_x_reg <= q_item.bx;
            dir_y_reg <= q_item.by;
            dir_z_reg <= q_item.bz;
            len_reg   <= q_item.len;
        end
        if (state_reg == ST_AXIS)
        begin
            lo_reg <= {ctr_sel[COORD_W-1], ctr_sel} - {half_sel[COORD_W-1], half_sel};
            hi_reg <= {ctr_sel[COORD_W-1], ctr_sel} + {half_sel[COORD_W-1], half_sel};
        end
        if (state_reg == ST_DWAIT && div_rsp.done && !side_reg)
        begin
            t0_reg <= div_rsp.q;
        end
        if (state_reg == ST_BOX)
        begin
            near_reg <= '0;
            far_reg  <= len_ext;
        end
        else if (state_reg == ST_MERGE)
        begin
            near_reg <= nn;
            far_reg  <= ff;
        end
        if (((state_reg == ST_CHECK && dir_sel == '0) || state_reg == ST_MERGE)
            && axis_pass && axis_reg == AXIS_Z && better)
        begin
            best_idx_reg  <= idx_t'(box_cnt_reg);
            best_dist_reg <= new_near;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_hit_reg  <= found_reg;
            out_idx_reg  <= found_reg ? best_idx_reg : '0;
            out_dist_reg <= found_reg ? best_dist_reg[LEN_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            box_cnt_reg   <= '0;
            axis_reg      <= AXIS_X;
            side_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && q_item.kind == KIND_WRITE)
            begin
                valid_reg[q_item.idx[IW-1:0]] <= q_item.active;
            end
            if (q_pop && q_item.kind == KIND_PICK)
            begin
                box_cnt_reg <= '0;
                found_reg   <= 1'b0;
            end
            if (state_reg == ST_BOX && box_cnt_reg != CW'(SCAN))
            begin
                axis_reg <= AXIS_X;
                if (!valid_reg[cur])
                begin
                    box_cnt_reg <= box_cnt_reg + 1'b1;
                end
            end
            if (state_reg == ST_CHECK)
            begin
                side_reg <= 1'b0;
            end
            if (state_reg == ST_DWAIT && div_rsp.done)
            begin
                side_reg <= 1'b1;
            end
            if ((state_reg == ST_CHECK && dir_sel == '0) || state_reg == ST_MERGE)
            begin
                if (!axis_pass || axis_reg == AXIS_Z)
                begin
                    box_cnt_reg <= box_cnt_reg + 1'b1;
                    if (axis_pass && better)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                else
                begin
                    axis_reg <= axis_reg + 1'b1;
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `RBNP_ASSERT_SAME(a_pop_only_idle, q_pop, state_reg == ST_IDLE && q_valid, "pop outside idle")
    `RBNP_ASSERT_NEXT(a_start_then_wait, div_req.start, state_reg == ST_DWAIT, "divider not awaited")
    `RBNP_ASSERT_SAME(a_done_in_wait, div_rsp.done, state_reg == ST_DWAIT, "stray divider result")
    `RBNP_ASSERT_SAME(a_best_in_range, found_reg, best_dist_reg >= 0 && best_dist_reg <= len_ext, "best distance out of range")

endmodule

`default_nettype wire

[rtl/ray_box_nearest_pick.sv]
`default_nettype none

// Nearest box along a ray. A write transfer stores one box (center, size, active flag)
// in a table of up to sixteen slots; writes to a slot at or beyond MAX_BOXES are dropped.
// A pick transfer casts a ray and returns one result: hit, index of the nearest active box
// enlarged by 1.5, and its Q15.16 entry distance (lowest index wins ties, zeros on a miss).
// Items enter a two-deep queue, so the input keeps taking transfers while a pick runs
// until the queue fills. A write is applied to the table as it leaves the queue. A pick
// scans the table slots in index order; for each active box it checks the X, Y and Z axes
// in turn and stops at the first axis the ray misses. An axis with zero direction tests
// the origin against the slab; any other axis runs two slab divisions, lower plane then
// upper, and a merge step. The result is held until the receiver takes it. Divisions
// use the one shared radix-2 divider, which retires one quotient bit a cycle; a division
// whose quotient reaches 2^32 in magnitude skips the bit steps and returns saturated.
module ray_box_nearest_pick #(
    parameter int MAX_BOXES = rbnp_pkg::MAX_BOXES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rbnp_in_if.sink     in_ch,
    rbnp_out_if.source  out_ch
);
    import rbnp_pkg::*;

    logic     push;
    item_t    push_item;
    logic     full;
    logic     q_valid;
    item_t    q_item;
    logic     q_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    rbnp_front #(
        .MAX_BOXES (MAX_BOXES)
    ) u_front (
        .in_ch     (in_ch),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    rbnp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_item)
    );

    rbnp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rbnp_back #(
        .MAX_BOXES (MAX_BOXES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

[verif/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbnp_pkg::*;

    localparam int NBOX = 16;
    localparam longint CYCLE_LIMIT = 15000000;

    typedef struct {
        logic hit;
        idx_t box_index;
        len_t hit_distance;
    } pick_result_t;

    logic clk;
    logic rst_n;

    rbnp_in_if  in_ch ();
    rbnp_out_if out_ch ();

    ray_box_nearest_pick dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Shadow copy of the box table.
    longint shadow_cx [NBOX];
    longint shadow_cy [NBOX];
    longint shadow_cz [NBOX];
    longint shadow_sx [NBOX];
    longint shadow_sy [NBOX];
    longint shadow_sz [NBOX];
    bit     shadow_on [NBOX];

    pick_result_t pending_picks[$];
    int  error_count;
    longint cycle_count;
    int  picks_seen;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic longint half_extent(longint size);
        longint v;
        longint q;
        v = size * 3;
        q = v / 4;
        if (v < 0 && (v % 4) != 0)
            q -= 1;
        return q;
    endfunction

    function automatic longint slab_t(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q;
    endfunction

    // Clips one axis into the running near/far interval; 0 means the axis misses.
    function automatic bit clip_axis(longint org, longint dir, longint lo, longint hi,
                                     ref longint near_t, ref longint far_t);
        longint t0;
        longint t1;
        longint tmp;
        if (dir == 0)
            return org >= lo && org <= hi;
        t0 = slab_t(lo - org, dir);
        t1 = slab_t(hi - org, dir);
        if (t0 > t1)
        begin
            tmp = t0;
            t0 = t1;
            t1 = tmp;
        end
        if (t0 > near_t)
            near_t = t0;
        if (t1 < far_t)
            far_t = t1;
        return near_t <= far_t;
    endfunction

    function automatic pick_result_t nearest_box(longint ox, longint oy, longint oz,
                                                 longint dx, longint dy, longint dz,
                                                 longint len);
        pick_result_t r;
        longint near_t;
        longint far_t;
        longint h;
        bit ok;
        r.hit = 1'b0;
        r.box_index = '0;
        r.hit_distance = '0;
        for (int i = 0; i < NBOX; i++)
        begin
            if (!shadow_on[i])
                continue;
            near_t = 0;
            far_t = len;
            h = half_extent(shadow_sx[i]);
            ok = clip_axis(ox, dx, shadow_cx[i] - h, shadow_cx[i] + h, near_t, far_t);
            if (ok)
            begin
                h = half_extent(shadow_sy[i]);
                ok = clip_axis(oy, dy, shadow_cy[i] - h, shadow_cy[i] + h, near_t, far_t);
            end
            if (ok)
            begin
                h = half_extent(shadow_sz[i]);
                ok = clip_axis(oz, dz, shadow_cz[i] - h, shadow_cz[i] + h, near_t, far_t);
            end
            ok = ok && near_t <= len && far_t >= 0;
            if (ok && (!r.hit || near_t < longint'(r.hit_distance)))
            begin
                r.hit = 1'b1;
                r.box_index = idx_t'(i);
                r.hit_distance = len_t'(near_t);
            end
        end
        return r;
    endfunction

    // Leaves valid high on return, so a following item can go out back to back.
    task automatic send_item(input logic kind, input idx_t idx,
                             input coord_t ax, input coord_t ay, input coord_t az,
                             input coord_t bx, input coord_t by, input coord_t bz,
                             input len_t len, input logic active);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.entry_index  <= idx;
        in_ch.vec_a_x      <= ax;
        in_ch.vec_a_y      <= ay;
        in_ch.vec_a_z      <= az;
        in_ch.vec_b_x      <= bx;
        in_ch.vec_b_y      <= by;
        in_ch.vec_b_z      <= bz;
        in_ch.ray_length   <= len;
        in_ch.entry_active <= active;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (kind == KIND_WRITE)
        begin
            shadow_cx[idx] = ax;
            shadow_cy[idx] = ay;
            shadow_cz[idx] = az;
            shadow_sx[idx] = bx;
            shadow_sy[idx] = by;
            shadow_sz[idx] = bz;
            shadow_on[idx] = active;
        end
        else
            pending_picks.insert(pending_picks.size(), nearest_box(ax, ay, az, bx, by, bz, len));
        @(negedge clk);
    endtask

    // Result checker with a randomly stalling receiver.
    initial
    begin
        int stall;
        pick_result_t want;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            picks_seen++;
            if (pending_picks.size() == 0)
                report_mismatch("unexpected result", picks_seen, 0);
            else
            begin
                want = pending_picks.pop_front();
                if (out_ch.hit !== want.hit)
                    report_mismatch("hit", out_ch.hit, want.hit);
                if (out_ch.box_index !== want.box_index)
                    report_mismatch("box_index", out_ch.box_index, want.box_index);
                if (out_ch.hit_distance !== want.hit_distance)
                    report_mismatch("hit_distance", out_ch.hit_distance,
                                    want.hit_distance);
            end
        end
    end

    function automatic coord_t small_coord();
        return coord_t'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endfunction

    function automatic coord_t rand_dir();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return coord_t'($urandom);
            default: return coord_t'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        endcase
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_picks.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_box(input idx_t idx, input coord_t cx, input coord_t cy,
                             input coord_t cz, input coord_t sx, input coord_t sy,
                             input coord_t sz, input logic active);
        send_item(KIND_WRITE, idx, cx, cy, cz, sx, sy, sz, len_t'($urandom), active);
    endtask

    task automatic pick_ray(input coord_t ox, input coord_t oy, input coord_t oz,
                            input coord_t dx, input coord_t dy, input coord_t dz,
                            input len_t len);
        send_item(KIND_PICK, idx_t'($urandom), ox, oy, oz, dx, dy, dz, len, 1'($urandom));
    endtask

    task automatic test_empty_table();
        pick_ray(0, 0, 0, 32'sh10000, 0, 0, 31'h7fffffff);
    endtask

    task automatic test_directed_boxes();
        write_box(4'd0, 5 << 16, 0, 0, 2 << 16, 2 << 16, 2 << 16, 1'b1);
        write_box(4'd1, 5 << 16, 0, 0, 2 << 16, 2 << 16, 2 << 16, 1'b1);
        write_box(4'd15, 3 << 16, 0, 0, 1 << 16, 1 << 16, 1 << 16, 1'b1);
        pick_ray(0, 0, 0, 32'sh10000, 0, 0, 31'(100 << 16));
        // A zero direction axis with the origin exactly on the slab edge.
        pick_ray(0, 32'sh18000, 0, 32'sh10000, 0, 0, 31'(100 << 16));
        pick_ray(0, 0, 0, 32'sh10000, 0, 0, 31'(1 << 16));
        pick_ray(0, 0, 0, -32'sh10000, 0, 0, 31'(100 << 16));
        pick_ray(5 << 16, 0, 0, 0, 0, 0, 31'd0);
        write_box(4'd15, 3 << 16, 0, 0, 1 << 16, 1 << 16, 1 << 16, 1'b0);
        pick_ray(0, 0, 0, 32'sh10000, 0, 0, 31'(100 << 16));
        write_box(4'd2, 32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000,
                  -1, 1'b1);
        pick_ray(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1, -1, 32'sh7fffffff,
                 31'h7fffffff);
        pick_ray(32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 1, 31'd0);
        write_box(4'd3, 0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
        pick_ray(0, 0, 0, 1, 1, 1, 31'h7fffffff);
        wait_drained();
        for (int i = 0; i < NBOX; i++)
            write_box(idx_t'(i), 0, 0, 0, 0, 0, 0, 1'b0);
    endtask

    task automatic test_random_scenes(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_box(idx_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                              coord_t'($urandom), coord_t'($urandom),
                              coord_t'($urandom), coord_t'($urandom), 1'($urandom));
                else
                    write_box(idx_t'($urandom), small_coord(), small_coord(),
                              small_coord(), coord_t'($urandom_range(0, 6 << 16)),
                              coord_t'($urandom_range(0, 6 << 16)),
                              coord_t'($urandom_range(0, 6 << 16)),
                              $urandom_range(0, 4) != 0);
            end
            else if ($urandom_range(0, 15) == 0)
                pick_ray(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                         len_t'($urandom));
            else
                pick_ray(small_coord(), small_coord(), small_coord(), rand_dir(),
                         rand_dir(), rand_dir(),
                         $urandom_range(0, 3) == 0 ? len_t'($urandom)
                                                   : len_t'($urandom_range(0, 40 << 16)));
            if (n == count / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        picks_seen = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_WRITE;
        in_ch.entry_index = '0;
        in_ch.vec_a_x = '0;
        in_ch.vec_a_y = '0;
        in_ch.vec_a_z = '0;
        in_ch.vec_b_x = '0;
        in_ch.vec_b_y = '0;
        in_ch.vec_b_z = '0;
        in_ch.ray_length = '0;
        in_ch.entry_active = 1'b0;
        for (int i = 0; i < NBOX; i++)
            shadow_on[i] = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_table();
        test_directed_boxes();
        test_random_scenes(830);
        wait_drained();
        repeat (4000) @(negedge clk);
        if (error_count == 0 && pending_picks.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
